// ----- rtl/rc4ck_pkg.sv -----
// Shared constants, codes and interface structs of the keyed RC4 cipher unit.
package rc4ck_pkg;

    localparam int STATE_BYTES = 256;
    localparam int CHALLENGE_BYTES_DEF = 16;
    localparam int GAMEKEY_BYTES_DEF = 6;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = $clog2(STATE_BYTES);
    localparam int KIDX_W = 4;
    localparam int GIDX_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int GAMEKEY_W = 48;

    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(STATE_BYTES - 1);

    localparam logic CMD_KEY_SCHEDULE = 1'b0;
    localparam logic CMD_CRYPT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CHALLENGE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHALLENGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAME_KEY = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              command;
        logic [BYTE_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic              busy;
        logic              res_valid;
        logic [BYTE_W-1:0] res_byte;
    } rsp_t;

endpackage

// ----- rtl/rc4ck_core.sv -----
// Permutation memory and sequencer for the key schedule and the crypt step.
module rc4ck_core #(
    parameter int CHALLENGE_BYTES = rc4ck_pkg::CHALLENGE_BYTES_DEF,
    parameter int GAMEKEY_BYTES = rc4ck_pkg::GAMEKEY_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rc4ck_pkg::req_t                 req,
    input  logic                            out_free,
    input  logic [rc4ck_pkg::BYTE_W-1:0]    key_byte,
    output logic [rc4ck_pkg::KIDX_W-1:0]    key_idx,
    output logic [rc4ck_pkg::GIDX_W-1:0]    game_idx,
    output rc4ck_pkg::rsp_t                 rsp
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FILL = 8'b0000_0010,
        S_KA   = 8'b0000_0100,
        S_KB   = 8'b0000_1000,
        S_KC   = 8'b0001_0000,
        S_CA   = 8'b0010_0000,
        S_CB   = 8'b0100_0000,
        S_CC   = 8'b1000_0000
    } state_t;

    localparam logic [rc4ck_pkg::KIDX_W-1:0] KIDX_LAST =
        rc4ck_pkg::KIDX_W'(CHALLENGE_BYTES - 1);
    localparam logic [rc4ck_pkg::GIDX_W-1:0] GIDX_LAST =
        rc4ck_pkg::GIDX_W'(GAMEKEY_BYTES - 1);

    logic [rc4ck_pkg::BYTE_W-1:0] perm_mem [rc4ck_pkg::STATE_BYTES];
    logic [rc4ck_pkg::BYTE_W-1:0] rdata_reg;
    logic [rc4ck_pkg::ADDR_W-1:0] raddr;
    logic [rc4ck_pkg::ADDR_W-1:0] waddr;
    logic [rc4ck_pkg::BYTE_W-1:0] wdata;
    logic                         we;

    state_t state_reg, state_next;
    logic [rc4ck_pkg::ADDR_W-1:0] k_reg, k_next;
    logic [rc4ck_pkg::ADDR_W-1:0] acc_reg, acc_next;
    logic [rc4ck_pkg::ADDR_W-1:0] i_reg, i_next;
    logic [rc4ck_pkg::ADDR_W-1:0] j_reg, j_next;
    logic [rc4ck_pkg::ADDR_W-1:0] mix_reg, mix_next;
    logic [rc4ck_pkg::BYTE_W-1:0] hold_reg, hold_next;
    logic [rc4ck_pkg::BYTE_W-1:0] peer_reg, peer_next;
    logic [rc4ck_pkg::BYTE_W-1:0] data_reg, data_next;
    logic                         fwd_a_reg, fwd_a_next;
    logic                         fwd_b_reg, fwd_b_next;
    logic [rc4ck_pkg::KIDX_W-1:0] kidx_reg, kidx_next;
    logic [rc4ck_pkg::GIDX_W-1:0] gidx_reg, gidx_next;
    logic [rc4ck_pkg::BYTE_W-1:0] stream_byte;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= perm_mem[raddr];
    end

    always_comb
    begin
        if (fwd_a_reg)
        begin
            stream_byte = hold_reg;
        end
        else if (fwd_b_reg)
        begin
            stream_byte = peer_reg;
        end
        else
        begin
            stream_byte = rdata_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        i_next = i_reg;
        j_next = j_reg;
        mix_next = mix_reg;
        hold_next = hold_reg;
        peer_next = peer_reg;
        data_next = data_reg;
        fwd_a_next = fwd_a_reg;
        fwd_b_next = fwd_b_reg;
        kidx_next = kidx_reg;
        gidx_next = gidx_reg;
        raddr = mix_reg;
        waddr = k_reg;
        wdata = ~k_reg;
        we = 1'b0;
        rsp.busy = (state_reg != S_IDLE);
        rsp.res_valid = 1'b0;
        rsp.res_byte = data_reg ^ stream_byte;

        case (state_reg)
            S_IDLE:
            begin
                raddr = i_reg + 8'd1;
                if (req.valid)
                begin
                    data_next = req.data;
                    if (req.command == rc4ck_pkg::CMD_CRYPT)
                    begin
                        i_next = i_reg + 8'd1;
                        state_next = S_CA;
                    end
                    else
                    begin
                        k_next = '0;
                        acc_next = '0;
                        kidx_next = '0;
                        gidx_next = '0;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                we = 1'b1;
                waddr = k_reg;
                wdata = ~k_reg;
                raddr = '0;
                k_next = k_reg + 8'd1;
                if (k_reg == rc4ck_pkg::LAST_ENTRY)
                begin
                    state_next = S_KA;
                end
            end
            S_KA:
            begin
                hold_next = rdata_reg;
                acc_next = acc_reg + key_byte + rdata_reg;
                raddr = acc_next;
                state_next = S_KB;
            end
            S_KB:
            begin
                peer_next = rdata_reg;
                we = 1'b1;
                waddr = acc_reg;
                wdata = hold_reg;
                state_next = S_KC;
            end
            S_KC:
            begin
                we = 1'b1;
                waddr = k_reg;
                wdata = peer_reg;
                raddr = k_reg + 8'd1;
                k_next = k_reg + 8'd1;
                if (kidx_reg == KIDX_LAST)
                begin
                    kidx_next = '0;
                    gidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + 1'b1;
                    gidx_next = (gidx_reg == GIDX_LAST) ? '0 : gidx_reg + 1'b1;
                end
                if (k_reg == rc4ck_pkg::LAST_ENTRY)
                begin
                    i_next = '0;
                    j_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KA;
                end
            end
            S_CA:
            begin
                hold_next = rdata_reg;
                j_next = j_reg + rdata_reg;
                raddr = j_next;
                state_next = S_CB;
            end
            S_CB:
            begin
                peer_next = rdata_reg;
                we = 1'b1;
                waddr = i_reg;
                wdata = rdata_reg;
                mix_next = hold_reg + rdata_reg;
                raddr = mix_next;
                fwd_a_next = (mix_next == j_reg);
                fwd_b_next = (mix_next == i_reg);
                state_next = S_CC;
            end
            S_CC:
            begin
                we = 1'b1;
                waddr = j_reg;
                wdata = hold_reg;
                raddr = mix_reg;
                if (out_free)
                begin
                    rsp.res_valid = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign key_idx = kidx_reg;
    assign game_idx = gidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        acc_reg <= acc_next;
        mix_reg <= mix_next;
        hold_reg <= hold_next;
        peer_reg <= peer_next;
        data_reg <= data_next;
        fwd_a_reg <= fwd_a_next;
        fwd_b_reg <= fwd_b_next;
        kidx_reg <= kidx_next;
        gidx_reg <= gidx_next;
    end

endmodule

// ----- rtl/rc4_challenge_keyed_cipher_unit.sv -----
// Top level of the keyed RC4 cipher unit: key registers, key byte select and result register.
//
// A crypt request passes through S_CA, S_CB and S_CC before the next request is taken, and
// it holds in S_CC while the output register is full and stalled: the permutation lives
// in one RAM with one write and one registered read port, and the read of i, the read of j
// and the third read at the mixed index each wait for the RAM. A key schedule request first
// fills the permutation in descending order, then does each of the 256 swaps in S_KA, S_KB
// and S_KC. It gives no result. The finished byte waits in an output register, so the next
// request is taken while an earlier result is still stalled. Run a key schedule before the
// first crypt request.
module rc4_challenge_keyed_cipher_unit #(
    parameter int CHALLENGE_BYTES = rc4ck_pkg::CHALLENGE_BYTES_DEF,
    parameter int GAMEKEY_BYTES = rc4ck_pkg::GAMEKEY_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [rc4ck_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rc4ck_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [rc4ck_pkg::BYTE_W-1:0]        data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rc4ck_pkg::BYTE_W-1:0]        out_byte
);

    logic [rc4ck_pkg::CFG_DATA_W-1:0] chal_low_reg;
    logic [rc4ck_pkg::CFG_DATA_W-1:0] chal_high_reg;
    logic [rc4ck_pkg::GAMEKEY_W-1:0]  game_key_reg;
    logic                             out_valid_reg;
    logic [rc4ck_pkg::BYTE_W-1:0]     out_byte_reg;

    rc4ck_pkg::req_t                  req;
    rc4ck_pkg::rsp_t                  rsp;
    logic                             out_free;
    logic [rc4ck_pkg::KIDX_W-1:0]     key_idx;
    logic [rc4ck_pkg::GIDX_W-1:0]     game_idx;
    logic [2*rc4ck_pkg::CFG_DATA_W-1:0] chal_word;
    logic [rc4ck_pkg::CFG_DATA_W-1:0] game_word;
    logic [rc4ck_pkg::BYTE_W-1:0]     key_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chal_low_reg <= '0;
            chal_high_reg <= '0;
            game_key_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rc4ck_pkg::REG_CHALLENGE_LOW:  chal_low_reg <= cfg_data;
                rc4ck_pkg::REG_CHALLENGE_HIGH: chal_high_reg <= cfg_data;
                rc4ck_pkg::REG_GAME_KEY:
                    game_key_reg <= cfg_data[rc4ck_pkg::GAMEKEY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign chal_word = {chal_high_reg, chal_low_reg};
    assign game_word = {{(rc4ck_pkg::CFG_DATA_W - rc4ck_pkg::GAMEKEY_W){1'b0}}, game_key_reg};
    assign key_byte = chal_word[{key_idx, 3'b000} +: rc4ck_pkg::BYTE_W]
                    ^ game_word[{game_idx, 3'b000} +: rc4ck_pkg::BYTE_W];

    assign req.valid = in_valid;
    assign req.command = command;
    assign req.data = data_byte;
    assign in_stall = rsp.busy;
    assign out_free = !out_valid_reg || !out_stall;

    rc4ck_core #(
        .CHALLENGE_BYTES (CHALLENGE_BYTES),
        .GAMEKEY_BYTES   (GAMEKEY_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .key_byte (key_byte),
        .key_idx  (key_idx),
        .game_idx (game_idx),
        .rsp      (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp.res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp.res_valid)
        begin
            out_byte_reg <= rsp.res_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;

endmodule

// ----- tb/tb_rc4_challenge_keyed_cipher_unit.sv -----
// Self-checking testbench of the keyed RC4 cipher unit with its own keystream predictor.
module tb_rc4_challenge_keyed_cipher_unit;

    localparam logic [rc4ck_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 1100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES = 7;

    class rc4_keystream_board;
        logic [rc4ck_pkg::CFG_DATA_W-1:0] challenge_lo;
        logic [rc4ck_pkg::CFG_DATA_W-1:0] challenge_hi;
        logic [rc4ck_pkg::GAMEKEY_W-1:0] game_key;
        logic [rc4ck_pkg::BYTE_W-1:0] perm [rc4ck_pkg::STATE_BYTES];
        logic [rc4ck_pkg::BYTE_W-1:0] pos_i;
        logic [rc4ck_pkg::BYTE_W-1:0] pos_j;
        logic [rc4ck_pkg::BYTE_W-1:0] expected_bytes [$];
        int errors;
        int requests;
        int schedules;
        int checked;

        function new();
            challenge_lo = '0;
            challenge_hi = '0;
            game_key = '0;
            pos_i = '0;
            pos_j = '0;
            errors = 0;
            requests = 0;
            schedules = 0;
            checked = 0;
        endfunction

        function void set_register(logic [rc4ck_pkg::CFG_IDX_W-1:0] idx,
                                   logic [rc4ck_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                rc4ck_pkg::REG_CHALLENGE_LOW: challenge_lo = value;
                rc4ck_pkg::REG_CHALLENGE_HIGH: challenge_hi = value;
                rc4ck_pkg::REG_GAME_KEY: game_key = value[rc4ck_pkg::GAMEKEY_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic cmd, logic [rc4ck_pkg::BYTE_W-1:0] data);
            logic [rc4ck_pkg::BYTE_W-1:0] key [rc4ck_pkg::CHALLENGE_BYTES_DEF];
            logic [rc4ck_pkg::BYTE_W-1:0] acc;
            logic [rc4ck_pkg::BYTE_W-1:0] held;
            logic [rc4ck_pkg::BYTE_W-1:0] mix;
            int k;
            requests++;
            if (cmd == rc4ck_pkg::CMD_KEY_SCHEDULE)
            begin
                schedules++;
                for (k = 0; k < rc4ck_pkg::CHALLENGE_BYTES_DEF; k++)
                begin
                    key[k] = (k < 8 ? challenge_lo[8*k +: 8] : challenge_hi[8*(k-8) +: 8])
                             ^ game_key[8*(k % rc4ck_pkg::GAMEKEY_BYTES_DEF) +: 8];
                end
                for (k = 0; k < rc4ck_pkg::STATE_BYTES; k++)
                    perm[k] = rc4ck_pkg::LAST_ENTRY - rc4ck_pkg::BYTE_W'(k);
                acc = '0;
                for (k = 0; k < rc4ck_pkg::STATE_BYTES; k++)
                begin
                    acc = acc + key[k % rc4ck_pkg::CHALLENGE_BYTES_DEF] + perm[k];
                    held = perm[acc];
                    perm[acc] = perm[k];
                    perm[k] = held;
                end
                pos_i = '0;
                pos_j = '0;
            end
            else
            begin
                pos_i = pos_i + 1'b1;
                held = perm[pos_i];
                pos_j = pos_j + held;
                perm[pos_i] = perm[pos_j];
                perm[pos_j] = held;
                mix = held + perm[pos_i];
                expected_bytes.push_back(data ^ perm[mix]);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [rc4ck_pkg::BYTE_W-1:0] got);
            logic [rc4ck_pkg::BYTE_W-1:0] want;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("out_byte %02h with no request waiting", got));
            end
            else
            begin
                want = expected_bytes.pop_front();
                checked++;
                if (got !== want)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", got, want));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [rc4ck_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rc4ck_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic command;
    logic [rc4ck_pkg::BYTE_W-1:0] data_byte;
    logic out_valid;
    logic out_stall;
    logic [rc4ck_pkg::BYTE_W-1:0] out_byte;

    rc4_keystream_board board;
    bit steady;
    int hold_off;

    rc4_challenge_keyed_cipher_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_request(command, data_byte);
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_byte);
    end

    task automatic send_request(input logic cmd, input logic [rc4ck_pkg::BYTE_W-1:0] data);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        command = cmd;
        data_byte = data;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random();
        send_request($urandom_range(0, 99) < 3 ? rc4ck_pkg::CMD_KEY_SCHEDULE
                                               : rc4ck_pkg::CMD_CRYPT,
                     rc4ck_pkg::BYTE_W'($urandom));
    endtask

    task automatic write_register(input logic [rc4ck_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rc4ck_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
        board.set_register(idx, value);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stall before each result except in the steady phase, plus an occasional long hold-off.
    initial
    begin
        int gap;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = steady ? 0 : $urandom_range(0, 3);
            if (hold_off > 0)
            begin
                out_stall = 1'b1;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            if (gap > 0)
            begin
                out_stall = 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #6000000;
        $display("tb_rc4_challenge_keyed_cipher_unit: done, errors");
        $finish;
    end

    initial
    begin
        int phase;
        board = new();
        steady = 1'b0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = rc4ck_pkg::CMD_KEY_SCHEDULE;
        data_byte = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1:
                    begin
                        write_register(rc4ck_pkg::REG_CHALLENGE_LOW, '1);
                        write_register(rc4ck_pkg::REG_CHALLENGE_HIGH, '1);
                        write_register(rc4ck_pkg::REG_GAME_KEY, '1);
                        write_register(REG_UNUSED, {$urandom, $urandom});
                    end
                    2:
                    begin
                        write_register(rc4ck_pkg::REG_CHALLENGE_LOW, '0);
                        write_register(rc4ck_pkg::REG_CHALLENGE_HIGH, '0);
                        write_register(rc4ck_pkg::REG_GAME_KEY, {$urandom, $urandom});
                    end
                    6:
                    begin
                        write_register(rc4ck_pkg::REG_CHALLENGE_LOW, '1);
                        write_register(rc4ck_pkg::REG_CHALLENGE_HIGH, '0);
                        write_register(rc4ck_pkg::REG_GAME_KEY, '0);
                        write_register(REG_UNUSED, '1);
                    end
                    default:
                    begin
                        write_register(rc4ck_pkg::REG_CHALLENGE_LOW, {$urandom, $urandom});
                        write_register(rc4ck_pkg::REG_CHALLENGE_HIGH, {$urandom, $urandom});
                        write_register(rc4ck_pkg::REG_GAME_KEY, {$urandom, $urandom});
                    end
                endcase
            end
            steady = (phase == 3);
            if (phase == 1 || phase == 4)
                hold_off = HOLD_OFF_CYCLES;
            send_request(rc4ck_pkg::CMD_KEY_SCHEDULE, rc4ck_pkg::BYTE_W'($urandom));
            if (phase == 0)
            begin
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h00);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hFF);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h01);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h80);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h7F);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hFE);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h55);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hAA);
                send_request(rc4ck_pkg::CMD_KEY_SCHEDULE, 8'hFF);
                send_request(rc4ck_pkg::CMD_KEY_SCHEDULE, 8'h00);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hFF);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hFF);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hFF);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h00);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h00);
                send_request(rc4ck_pkg::CMD_KEY_SCHEDULE, 8'h5A);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'h00);
                send_request(rc4ck_pkg::CMD_CRYPT, 8'hFF);
            end
            repeat (phase == 0 ? 260 : 240) send_random();
        end
        settle();

        if (board.expected_bytes.size() != 0)
            board.report_mismatch("results still expected at the end of the run");
        $display("Covered %0d requests (%0d key schedules) under %0d key settings.",
                 board.requests, board.schedules, PHASES);
        $display("Checked %0d cipher bytes; %0d mismatches.", board.checked, board.errors);
        if (board.errors == 0)
            $display("tb_rc4_challenge_keyed_cipher_unit: done, clean");
        else
            $display("tb_rc4_challenge_keyed_cipher_unit: done, errors");
        $finish;
    end

endmodule

// ----- rc4_challenge_keyed_cipher_unit.f -----
rtl/rc4ck_pkg.sv
rtl/rc4ck_core.sv
rtl/rc4_challenge_keyed_cipher_unit.sv
tb/tb_rc4_challenge_keyed_cipher_unit.sv
